FILE: hdl/nsrg_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nsrg_pkg : shared types for the natural selection run generator
// Controller states, drain modes and the command and status groups that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package nsrg_pkg;

    localparam int KEY_W  = 32;
    localparam int PAY_W  = 32;
    localparam int RUN_W  = 16;
    localparam int CFG_W  = 5;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [RUN_W-1:0] RUN_FIRST = 1;
    localparam logic [RUN_W-1:0] RUN_MAX   = '1;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_R_CHECK,
        ST_R_SCAN,
        ST_R_DECIDE,
        ST_R_RES,
        ST_D_SCAN,
        ST_D_DECIDE,
        ST_COPY
    } state_t;

    typedef enum logic [1:0] {
        MODE_REC,
        MODE_END1,
        MODE_END2
    } mode_t;

    typedef struct packed {
        logic load;
        logic insert;
        logic scan_start;
        logic scan_step;
        logic emit;
        logic emit_last;
        logic invalidate;
        logic replace;
        logic set_last;
        logic push_res;
        logic clear_fill;
        logic next_run;
        logic copy_start;
        logic copy_step;
        logic reset_last;
        logic clear_sort;
    } dp_cmd_t;

    typedef struct packed {
        logic item_end;
        logic fill_lt_n;
        logic scan_last;
        logic found;
        logic below_last;
        logic res_lt_n;
        logic res_zero;
        logic copy_last;
        logic one_left;
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: hdl/natural_selection_run_generator_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// natural_selection_run_generator_unit : replacement-selection run builder
// Builds sorted runs from a record stream using a working memory and a
// reservoir, for the run formation phase of an external sort.
// ---------------------------------------------------------------------------
//  channel   dir  handshake           content
//  s_*       in   s_tvalid/s_tready   tuser: cmd; tdata: key, payload
//  m_*       out  m_tvalid/m_tready   tdata: key, payload, run; tlast: last
//  cfg_*     in   cfg_we              entries in use (5 bits)
//
//  A record while filling passes the start and check states; one written to
//  the run or sent to the reservoir also waits for a full scan by the single
//  comparator, as does each drained record. A reservoir reload moves one
//  entry per cycle.
//  Reset clears the sort state at once; entries in use returns to 16.
//  A stalled output holds the sequencer only when a further result is due.
// ---------------------------------------------------------------------------
module natural_selection_run_generator_unit #(
    parameter int MEMORY_DEPTH = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [63:0]  s_tdata,   // record_key[31:0], record_payload[63:32]
    input  wire [0:0]   s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [79:0] m_tdata,   // out_key[31:0], out_payload[63:32], run_number[79:64]
    output logic        m_tlast,
    input  wire         cfg_we,
    input  wire [4:0]   cfg_wdata
);
    import nsrg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_fire;

    assign in_fire = s_tvalid && s_tready;

    nsrg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nsrg_datapath #(
        .MEMORY_DEPTH (MEMORY_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_cmd     (s_tuser[0]),
        .in_key     (s_tdata[31:0]),
        .in_payload (s_tdata[63:32]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(m_tvalid && !m_tready))
        else $error("result overwritten while stalled");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("input accepted while busy");

    // reservoir reload only with entries present
    a_copy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_step |-> !status.res_zero)
        else $error("reload from empty reservoir");

endmodule
`default_nettype wire

FILE: hdl/nsrg_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nsrg_datapath : working memory, reservoir and result register
// Holds the records, runs the one-comparator minimum scan, moves records
// between memory and reservoir and drives the output channel.
// ---------------------------------------------------------------------------
module nsrg_datapath #(
    parameter int MEMORY_DEPTH = 16
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  nsrg_pkg::dp_cmd_t        cmd,
    output nsrg_pkg::dp_status_t     status,
    input  wire                      cfg_we,
    input  wire [4:0]                cfg_wdata,
    input  wire                      in_cmd,
    input  wire [31:0]               in_key,
    input  wire [31:0]               in_payload,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    output logic [79:0]              m_tdata,
    output logic                     m_tlast
);
    import nsrg_pkg::*;

    localparam int IDX_W = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(MEMORY_DEPTH + 1);

    // record stores
    logic signed [KEY_W-1:0] mem_key [MEMORY_DEPTH];
    logic        [PAY_W-1:0] mem_pay [MEMORY_DEPTH];
    logic signed [KEY_W-1:0] res_key [MEMORY_DEPTH];
    logic        [PAY_W-1:0] res_pay [MEMORY_DEPTH];

    logic [MEMORY_DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0]        fill_reg;
    logic [CNT_W-1:0]        res_cnt_reg;
    logic signed [KEY_W-1:0] last_key_reg;
    logic [RUN_W-1:0]        run_reg;
    logic [CFG_W-1:0]        cfg_reg;

    logic                    item_end_reg;
    logic signed [KEY_W-1:0] rec_key_reg;
    logic [PAY_W-1:0]        rec_pay_reg;

    logic [IDX_W-1:0]        scan_idx_reg;
    logic [IDX_W-1:0]        copy_idx_reg;
    logic                    found_reg;
    logic signed [KEY_W-1:0] best_key_reg;
    logic [PAY_W-1:0]        best_pay_reg;
    logic [IDX_W-1:0]        best_idx_reg;

    logic                    out_valid_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic [PAY_W-1:0]        out_pay_reg;
    logic [RUN_W-1:0]        out_run_reg;
    logic                    out_last_reg;

    logic [5:0]              n_wide;
    logic [CNT_W-1:0]        n_use;
    logic [IDX_W-1:0]        free_idx;
    logic signed [KEY_W-1:0] scan_key;
    logic                    scan_take;

    // clamp the entries-in-use register to 1..MEMORY_DEPTH
    always_comb
    begin
        n_wide = {1'b0, cfg_reg};
        if (n_wide == 6'd0)
            n_wide = 6'd1;
        if (n_wide > 6'(MEMORY_DEPTH))
            n_wide = 6'(MEMORY_DEPTH);
        n_use = CNT_W'(n_wide);
    end

    // find the lowest free memory slot
    always_comb
    begin
        free_idx = '0;
        for (int i = MEMORY_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_idx = IDX_W'(i);
        end
    end

    assign scan_key  = mem_key[scan_idx_reg];
    assign scan_take = valid_reg[scan_idx_reg] && (!found_reg || (scan_key < best_key_reg));

    // status towards the controller
    always_comb
    begin
        status.item_end   = item_end_reg;
        status.fill_lt_n  = fill_reg < n_use;
        status.scan_last  = scan_idx_reg == IDX_W'(MEMORY_DEPTH - 1);
        status.found      = found_reg;
        status.below_last = best_key_reg < last_key_reg;
        status.res_lt_n   = res_cnt_reg < n_use;
        status.res_zero   = res_cnt_reg == '0;
        status.copy_last  = (CNT_W'(copy_idx_reg) + CNT_W'(1)) == res_cnt_reg;
        status.one_left   = (valid_reg != '0) && ((valid_reg & (valid_reg - 1'b1)) == '0);
        status.out_busy   = out_valid_reg && !m_tready;
    end

    // record stores: no reset, written by slot
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            mem_key[free_idx] <= rec_key_reg;
            mem_pay[free_idx] <= rec_pay_reg;
        end
        if (cmd.replace)
        begin
            mem_key[best_idx_reg] <= rec_key_reg;
            mem_pay[best_idx_reg] <= rec_pay_reg;
        end
        if (cmd.copy_step)
        begin
            mem_key[copy_idx_reg] <= res_key[copy_idx_reg];
            mem_pay[copy_idx_reg] <= res_pay[copy_idx_reg];
        end
        if (cmd.push_res && (res_cnt_reg < CNT_W'(MEMORY_DEPTH)))
        begin
            res_key[res_cnt_reg[IDX_W-1:0]] <= best_key_reg;
            res_pay[res_cnt_reg[IDX_W-1:0]] <= best_pay_reg;
        end
    end

    // item latch, scan and result data registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rec_key_reg <= in_key;
            rec_pay_reg <= in_payload;
        end
        if (cmd.scan_step && scan_take)
        begin
            best_key_reg <= scan_key;
            best_pay_reg <= mem_pay[scan_idx_reg];
            best_idx_reg <= scan_idx_reg;
        end
        if (cmd.emit)
        begin
            out_key_reg  <= best_key_reg;
            out_pay_reg  <= best_pay_reg;
            out_run_reg  <= run_reg;
            out_last_reg <= cmd.emit_last;
        end
    end

    // control state of the sort
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fill_reg      <= '0;
            res_cnt_reg   <= '0;
            last_key_reg  <= KEY_MIN;
            run_reg       <= RUN_FIRST;
            cfg_reg       <= CFG_RESET;
            item_end_reg  <= 1'b0;
            scan_idx_reg  <= '0;
            copy_idx_reg  <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            if (cmd.load)
                item_end_reg <= in_cmd;

            // insert while filling
            if (cmd.insert)
            begin
                valid_reg[free_idx] <= 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end

            // scan one slot a cycle
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_take)
                    found_reg <= 1'b1;
            end

            if (cmd.invalidate)
                valid_reg[best_idx_reg] <= 1'b0;
            if (cmd.set_last)
                last_key_reg <= best_key_reg;
            if (cmd.reset_last)
                last_key_reg <= KEY_MIN;
            if (cmd.push_res && (res_cnt_reg < CNT_W'(MEMORY_DEPTH)))
                res_cnt_reg <= res_cnt_reg + 1'b1;
            if (cmd.clear_fill)
                fill_reg <= '0;
            if (cmd.next_run && (run_reg != RUN_MAX))
                run_reg <= run_reg + 1'b1;

            // move the reservoir into memory
            if (cmd.copy_start)
                copy_idx_reg <= '0;
            else if (cmd.copy_step)
            begin
                copy_idx_reg <= copy_idx_reg + 1'b1;
                valid_reg[copy_idx_reg] <= 1'b1;
                if (status.copy_last)
                begin
                    fill_reg    <= res_cnt_reg;
                    res_cnt_reg <= '0;
                end
            end

            if (cmd.clear_sort)
            begin
                valid_reg    <= '0;
                fill_reg     <= '0;
                res_cnt_reg  <= '0;
                last_key_reg <= KEY_MIN;
                run_reg      <= RUN_FIRST;
            end

            // result register: load on emit, drop once taken
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_run_reg, out_pay_reg, out_key_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

FILE: hdl/nsrg_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nsrg_ctrl : sequencing state machine
// Steps each transaction through fill, scan, emit, reservoir, reload and drain
// phases by issuing datapath commands.
// ---------------------------------------------------------------------------
module nsrg_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_fire,
    output logic                  in_ready,
    input  nsrg_pkg::dp_status_t  status,
    output nsrg_pkg::dp_cmd_t     cmd
);
    import nsrg_pkg::*;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_REC;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = ST_START;
            ST_START:
                if (status.item_end)
                begin
                    mode_next  = MODE_END1;
                    state_next = ST_D_SCAN;
                end
                else
                    state_next = ST_R_CHECK;
            ST_R_CHECK:
                state_next = status.fill_lt_n ? ST_IDLE : ST_R_SCAN;
            ST_R_SCAN:
                if (status.scan_last)
                    state_next = ST_R_DECIDE;
            ST_R_DECIDE:
                priority if (!status.found)
                    state_next = ST_R_CHECK;
                else if (status.below_last)
                    state_next = ST_R_RES;
                else if (!status.out_busy)
                    state_next = ST_IDLE;
            ST_R_RES:
                if (status.res_lt_n)
                    state_next = ST_IDLE;
                else
                begin
                    mode_next  = MODE_REC;
                    state_next = ST_D_SCAN;
                end
            ST_D_SCAN:
                if (status.scan_last)
                    state_next = ST_D_DECIDE;
            ST_D_DECIDE:
                priority if (status.found)
                begin
                    if (!status.out_busy)
                        state_next = ST_D_SCAN;
                end
                else if (mode_reg == MODE_REC)
                    state_next = ST_COPY;
                else if ((mode_reg == MODE_END1) && !status.res_zero)
                begin
                    mode_next  = MODE_END2;
                    state_next = ST_COPY;
                end
                else
                    state_next = ST_IDLE;
            ST_COPY:
                if (status.copy_last)
                    state_next = (mode_reg == MODE_REC) ? ST_R_CHECK : ST_D_SCAN;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            ST_START:
                cmd.scan_start = status.item_end;
            ST_R_CHECK:
                if (status.fill_lt_n)
                    cmd.insert = 1'b1;
                else
                    cmd.scan_start = 1'b1;
            ST_R_SCAN, ST_D_SCAN:
                cmd.scan_step = 1'b1;
            ST_R_DECIDE:
                priority if (!status.found)
                    cmd.clear_fill = 1'b1;
                else if (status.below_last)
                    cmd.push_res = 1'b1;
                else if (!status.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.set_last  = 1'b1;
                    cmd.replace   = 1'b1;
                end
            ST_R_RES:
                if (status.res_lt_n)
                    cmd.replace = 1'b1;
                else
                begin
                    cmd.invalidate = 1'b1;
                    cmd.scan_start = 1'b1;
                end
            ST_D_DECIDE:
                priority if (status.found)
                begin
                    if (!status.out_busy)
                    begin
                        cmd.emit       = 1'b1;
                        cmd.invalidate = 1'b1;
                        cmd.scan_start = 1'b1;
                        if (mode_reg == MODE_END1)
                            cmd.emit_last = status.one_left && status.res_zero;
                        else if (mode_reg == MODE_END2)
                            cmd.emit_last = status.one_left;
                    end
                end
                else if (mode_reg == MODE_REC)
                begin
                    cmd.clear_fill = 1'b1;
                    cmd.next_run   = 1'b1;
                    cmd.copy_start = 1'b1;
                end
                else if ((mode_reg == MODE_END1) && !status.res_zero)
                begin
                    cmd.clear_fill = 1'b1;
                    cmd.next_run   = 1'b1;
                    cmd.copy_start = 1'b1;
                end
                else
                    cmd.clear_sort = 1'b1;
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.copy_last)
                begin
                    if (mode_reg == MODE_REC)
                        cmd.reset_last = 1'b1;
                    else
                        cmd.scan_start = 1'b1;
                end
            end
            default:
                cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: tb/nsrg_run_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// nsrg_run_checker : scoreboard for the natural selection run generator
// Watches the record, result and register channels, keeps its own copy of
// the working memory, reservoir and run state, works out the records each
// accepted transaction should write and compares them in order.
// ---------------------------------------------------------------------------
module nsrg_run_checker #(
    parameter logic CMD_END = 1'b1,
    parameter int   DEPTH   = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire [63:0]  s_tdata,   // record_key[31:0], record_payload[63:32]
    input  wire [0:0]   s_tuser,   // cmd[0]
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire [79:0]  m_tdata,   // out_key[31:0], out_payload[63:32], run_number[79:64]
    input  wire         m_tlast,
    input  wire         cfg_we,
    input  wire [4:0]   cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    import nsrg_pkg::*;

    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
        logic [RUN_W-1:0]        run;
        logic                    last;
    } run_record_t;

    run_record_t             written_q[$];

    logic signed [KEY_W-1:0] mem_key [DEPTH];
    logic [PAY_W-1:0]        mem_pay [DEPTH];
    logic                    mem_vld [DEPTH];
    logic signed [KEY_W-1:0] res_key [DEPTH];
    logic [PAY_W-1:0]        res_pay [DEPTH];
    int                      res_cnt;
    int                      fill;
    logic signed [KEY_W-1:0] last_key;
    logic [RUN_W-1:0]        run_ctr;
    logic [CFG_W-1:0]        entries_reg;

    // Return to an empty sort, run one
    task automatic clear_sort();
        for (int i = 0; i < DEPTH; i++)
        begin
            mem_vld[i] = 1'b0;
        end
        res_cnt  = 0;
        fill     = 0;
        last_key = KEY_MIN;
        run_ctr  = RUN_FIRST;
    endtask

    function automatic int smallest_slot();
        int best;
        best = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (mem_vld[i] && (best < 0 || mem_key[i] < mem_key[best]))
                best = i;
        end
        return best;
    endfunction

    task automatic write_record(logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p);
        run_record_t r;
        r.key     = k;
        r.payload = p;
        r.run     = run_ctr;
        r.last    = 1'b0;
        written_q.push_back(r);
    endtask

    // Write the whole memory out in key order
    task automatic drain_memory();
        int m;
        m = smallest_slot();
        while (m >= 0)
        begin
            write_record(mem_key[m], mem_pay[m]);
            mem_vld[m] = 1'b0;
            m = smallest_slot();
        end
        fill = 0;
    endtask

    task automatic advance_run();
        if (run_ctr != RUN_MAX)
            run_ctr = run_ctr + 1'b1;
    endtask

    // Reservoir becomes the memory, in arrival order
    task automatic reload_memory();
        for (int i = 0; i < DEPTH; i++)
        begin
            mem_vld[i] = (i < res_cnt);
            if (i < res_cnt)
            begin
                mem_key[i] = res_key[i];
                mem_pay[i] = res_pay[i];
            end
        end
        fill    = res_cnt;
        res_cnt = 0;
    endtask

    task automatic predict_runs(logic cmd, logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p);
        int  before_cnt;
        int  n;
        int  m;
        bit  done;
        before_cnt = written_q.size();
        if (cmd == CMD_END)
        begin
            drain_memory();
            if (res_cnt > 0)
            begin
                advance_run();
                reload_memory();
                drain_memory();
            end
            clear_sort();
        end
        else
        begin
            // Out-of-range register values clamp to 1..DEPTH
            n = (entries_reg < 1) ? 1 : (entries_reg > DEPTH) ? DEPTH : int'(entries_reg);
            done = 1'b0;
            while (!done)
            begin
                if (fill < n)
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (!mem_vld[i])
                        begin
                            mem_key[i] = k;
                            mem_pay[i] = p;
                            mem_vld[i] = 1'b1;
                            fill++;
                            break;
                        end
                    end
                    done = 1'b1;
                end
                else
                begin
                    m = smallest_slot();
                    if (m < 0)
                        fill = 0;
                    else if (!(mem_key[m] < last_key))
                    begin
                        write_record(mem_key[m], mem_pay[m]);
                        last_key   = mem_key[m];
                        mem_key[m] = k;
                        mem_pay[m] = p;
                        done = 1'b1;
                    end
                    else
                    begin
                        if (res_cnt < DEPTH)
                        begin
                            res_key[res_cnt] = mem_key[m];
                            res_pay[res_cnt] = mem_pay[m];
                            res_cnt++;
                        end
                        if (res_cnt < n)
                        begin
                            mem_key[m] = k;
                            mem_pay[m] = p;
                            done = 1'b1;
                        end
                        else
                        begin
                            // Reservoir full: close the run, start the next
                            mem_vld[m] = 1'b0;
                            drain_memory();
                            advance_run();
                            reload_memory();
                            last_key = KEY_MIN;
                        end
                    end
                end
            end
        end
        if (written_q.size() > before_cnt)
            written_q[written_q.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sort();
            entries_reg  = CFG_RESET;
            written_q.delete();
            fail_count   = 0;
            results_seen = 0;
            pending      = 0;
        end
        else
        begin
            // Compare an accepted result with the oldest expectation
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (written_q.size() == 0)
                begin
                    $error("unexpected result key=%0d payload=%h run=%0d",
                           $signed(m_tdata[31:0]), m_tdata[63:32], m_tdata[79:64]);
                    fail_count++;
                end
                else
                begin
                    run_record_t e;
                    e = written_q.pop_front();
                    if (m_tdata[31:0] !== e.key)
                    begin
                        $error("out_key expected %0d actual %0d", e.key, $signed(m_tdata[31:0]));
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== e.payload)
                    begin
                        $error("out_payload expected %h actual %h", e.payload, m_tdata[63:32]);
                        fail_count++;
                    end
                    if (m_tdata[79:64] !== e.run)
                    begin
                        $error("run_number expected %0d actual %0d", e.run, m_tdata[79:64]);
                        fail_count++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("last_of_item expected %0b actual %0b", e.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            // Predict the records an accepted transaction writes
            if (s_tvalid && s_tready)
                predict_runs(s_tuser[0], s_tdata[31:0], s_tdata[63:32]);
            if (cfg_we)
                entries_reg = cfg_wdata;
            pending = written_q.size();
        end
    end

endmodule

FILE: tb/natural_selection_run_generator_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// natural_selection_run_generator_unit_test : run generator testbench
// Feeds directed and random records and end commands through several
// entries-in-use settings with random gaps and output stalls; the checker
// beside the block predicts every written record and reports mismatches.
// ---------------------------------------------------------------------------
module natural_selection_run_generator_unit_test;
    import nsrg_pkg::*;

    localparam logic CMD_RECORD  = 1'b0;
    localparam logic CMD_END     = 1'b1;
    localparam int   CYCLE_LIMIT = 2000000;
    localparam int   SETTLE      = 60;
    localparam int   PHASE_ITEMS = 28;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = CMD_RECORD;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          results_seen;
    int          items_sent;
    int          cfg_writes;
    int          cycles;
    int          long_hold;
    bit          quiet;

    always #5 clk = ~clk;

    natural_selection_run_generator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    nsrg_run_checker #(
        .CMD_END (CMD_END)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("natural_selection_run_generator_unit test failed");
            $finish;
        end
    end

    // Result side: random stalls per result, plus one long hold-off
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (long_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (long_hold) @(posedge clk);
                long_hold = 0;
            end
            stall = quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Offer one transaction; valid stays high afterwards until the next call
    task automatic send_item(logic cmd, logic signed [31:0] k, logic [31:0] p);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {p, k};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // Drop valid and wait for every expected result, then let the block go idle
    task automatic settle_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_entries(logic [4:0] v);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    // Mostly narrow keys so that ties and run breaks are frequent
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return KEY_MIN;
            1:       return 32'sh7fffffff;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    function automatic logic [31:0] pick_payload();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [4:0] plan [9];
        plan = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd5, 5'd2, 5'd16, 5'd4};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: end with nothing stored, then a small memory
        quiet = 1'b1;
        send_item(CMD_END, 0, 0);
        write_entries(5'd2);
        send_item(CMD_RECORD, 32'sh7fffffff, 32'hffffffff);  // filling
        send_item(CMD_RECORD, KEY_MIN, 32'h0);               // filling
        send_item(CMD_RECORD, 0, 32'h1);                     // writes the lowest key
        send_item(CMD_RECORD, 5, 32'h2);
        send_item(CMD_RECORD, 5, 32'h3);                     // equal keys
        send_item(CMD_RECORD, 5, 32'h4);
        send_item(CMD_RECORD, -7, 32'h5);
        send_item(CMD_RECORD, -8, 32'h6);                    // reservoir fills
        send_item(CMD_RECORD, -9, 32'h7);
        send_item(CMD_RECORD, -10, 32'h8);
        send_item(CMD_RECORD, 32'sh7fffffff, 32'haaaaaaaa);
        send_item(CMD_RECORD, KEY_MIN, 32'h55555555);
        send_item(CMD_END, 32'sh7fffffff, 32'hffffffff);     // drain everything
        send_item(CMD_RECORD, 3, 32'h9);
        send_item(CMD_END, 0, 0);                            // partly filled memory
        quiet = 1'b0;

        // Random phases over a spread of register settings
        for (int ph = 0; ph < 9; ph++)
        begin
            write_entries(plan[ph]);
            quiet = (ph == 4);
            if (ph == 7)
                long_hold = 400;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 3 && i == PHASE_ITEMS / 2)
                    settle_block();
                send_item(($urandom_range(0, 19) == 0) ? CMD_END : CMD_RECORD,
                          pick_key(), pick_payload());
            end
            // Odd phases leave the sort open across the register change
            if (ph % 2 == 0)
                send_item(CMD_END, pick_key(), pick_payload());
        end
        quiet = 1'b0;
        send_item(CMD_END, 0, 0);

        settle_block();
        $display("covered %0d transactions in, %0d records out, %0d register writes",
                 items_sent, results_seen, cfg_writes);
        $display("settings from 0 to 31 entries, ties, run breaks, mid-sort changes");
        if (fail_count == 0)
            $display("natural_selection_run_generator_unit test passed");
        else
            $display("natural_selection_run_generator_unit test failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/nsrg_pkg.sv
hdl/nsrg_datapath.sv
hdl/nsrg_ctrl.sv
hdl/natural_selection_run_generator_unit.sv
tb/nsrg_run_checker.sv
tb/natural_selection_run_generator_unit_test.sv
